// ----- hdl/outlier_gated_moving_average_assert.svh -----
// ----------------------------------------------------------------------------
// outlier_gated_moving_average_assert.svh
// Assertion macros for the outlier gated moving average block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OUTLIER_GATED_MOVING_AVERAGE_ASSERT_SVH
`define OUTLIER_GATED_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge
`define OGMA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ogma check failed");

// Condition that must hold in the cycle after a trigger
`define OGMA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("ogma check failed");

`else

`define OGMA_ASSERT_ALWAYS(lbl, cond)
`define OGMA_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ----- hdl/ogma_pkg.sv -----
// ----------------------------------------------------------------------------
// ogma_pkg
// Shared widths and defaults for the outlier gated moving average block.
// ----------------------------------------------------------------------------
package ogma_pkg;

    // sample and average word width
    localparam int OGMA_SAMPLE_W = 16;

    // tolerance register
    localparam int                     OGMA_TOL_W     = 16;
    localparam logic [OGMA_TOL_W-1:0]  OGMA_TOL_RESET = 16'd150;

    // default window length (power of two)
    localparam int OGMA_WINDOW_DEF = 512;

endpackage

// ----- hdl/ogma_ram.sv -----
// ----------------------------------------------------------------------------
// ogma_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address written at the same edge returns the old contents.
// ----------------------------------------------------------------------------
module ogma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/ogma_mean.sv -----
// ----------------------------------------------------------------------------
// ogma_mean
// Average of the window from running sum and fill count, registered.
// Full window: sum / WINDOW rounded half away from zero.
// Partial window: sum * count / WINDOW^2 truncated toward zero.
// ----------------------------------------------------------------------------
module ogma_mean
    import ogma_pkg::*;
#(
    parameter int WINDOW = OGMA_WINDOW_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_load,
    input  logic signed [OGMA_SAMPLE_W+$clog2(WINDOW)-1:0]  i_sum,
    input  logic        [$clog2(WINDOW):0]                  i_count,
    output logic signed [OGMA_SAMPLE_W-1:0]                 o_mean
);

    localparam int L   = $clog2(WINDOW);
    localparam int SW  = OGMA_SAMPLE_W + L;
    localparam int SW1 = SW + 1;
    localparam int CW  = L + 1;
    localparam int PW  = SW + CW + 1;

    logic signed [PW-1:0]            w_prod;
    logic signed [PW-1:0]            w_prod_adj;
    logic                            w_sum_pos;
    logic signed [SW1-1:0]           w_rnd_adj;
    logic signed [OGMA_SAMPLE_W-1:0] w_mean;
    logic signed [OGMA_SAMPLE_W-1:0] r_mean;

    // partial window: scaled product, bias negatives for truncation toward zero
    assign w_prod     = PW'(i_sum) * PW'($signed({1'b0, i_count}));
    assign w_prod_adj = w_prod + (w_prod[PW-1] ? PW'(WINDOW * WINDOW - 1) : PW'(0));

    // full window: round half away from zero, then truncate toward zero
    assign w_sum_pos = !i_sum[SW-1] && (i_sum != '0);
    assign w_rnd_adj = w_sum_pos ? (SW1'(i_sum) + SW1'(WINDOW / 2))
                                 : (SW1'(i_sum) - SW1'(WINDOW / 2) + SW1'(WINDOW - 1));

    assign w_mean = i_count[L] ? w_rnd_adj[L+OGMA_SAMPLE_W-1:L]
                               : w_prod_adj[2*L+OGMA_SAMPLE_W-1:2*L];

    // result register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mean <= w_mean;
        end
    end

    assign o_mean = r_mean;

endmodule

// ----- hdl/outlier_gated_moving_average.sv -----
// ----------------------------------------------------------------------------
// outlier_gated_moving_average
// Moving average over a ring of WINDOW samples that, once the ring is full,
// drops samples farther than the tolerance from the current mean.
//
//   channel   direction  valid / stall          word
//   -------   ---------  ---------------------  ---------------------------
//   input     in         i_valid / o_stall      i_sample
//   output    out        o_valid / i_stall      o_mean_out, o_accepted,
//                                               o_window_full
//   config    in         i_cfg_wr_en            i_cfg_wr_data (tolerance)
//
// One word per cycle unless the output stalls; each word passes the middle
// and then the output stage. Ring, sum, count and pointer update when a
// word is stored, so the next word sees them; the ring entry to replace is
// read ahead at the next pointer. A stalled output word holds while the
// middle stage can still take one word. Synchronous active-low reset;
// o_stall is high while reset is applied. WINDOW must be a power of two.
// ----------------------------------------------------------------------------
module outlier_gated_moving_average
    import ogma_pkg::*;
#(
    parameter int WINDOW = OGMA_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [OGMA_SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [OGMA_SAMPLE_W-1:0] o_mean_out,
    output logic                            o_accepted,
    output logic                            o_window_full,
    input  logic                            i_cfg_wr_en,
    input  logic [OGMA_TOL_W-1:0]           i_cfg_wr_data
);

    localparam int L  = $clog2(WINDOW);
    localparam int SW = OGMA_SAMPLE_W + L;
    localparam int CW = L + 1;
    localparam int DW = OGMA_SAMPLE_W + 1;

    // window state
    logic signed [SW-1:0]        r_sum, n_sum;
    logic [CW-1:0]               r_count, n_count;
    logic [L-1:0]                r_ptr, n_ptr;
    logic [OGMA_TOL_W-1:0]       r_tol;

    // middle stage
    logic                        r_b_valid;
    logic signed [SW-1:0]        r_b_sum;
    logic [CW-1:0]               r_b_count;
    logic                        r_b_acc;

    // output stage
    logic                        r_o_valid;
    logic                        r_o_acc;
    logic                        r_o_full;

    logic                        w_full;
    logic                        w_in_acc;
    logic                        w_out_ready;
    logic                        w_load_out;
    logic                        w_b_ready;
    logic [OGMA_SAMPLE_W-1:0]    w_rd_data;
    logic signed [SW-1:0]        w_avg_adj;
    logic signed [OGMA_SAMPLE_W-1:0] w_avg;
    logic signed [DW-1:0]        w_diff;
    logic [DW-1:0]               w_mag;
    logic                        w_store;
    logic                        w_store_go;
    logic signed [OGMA_SAMPLE_W-1:0] w_old;

    assign w_full = r_count[L];

    // handshake
    assign w_out_ready = !r_o_valid || !i_stall;
    assign w_load_out  = r_b_valid && w_out_ready;
    assign w_b_ready   = !r_b_valid || w_load_out;
    assign o_stall     = !w_b_ready || !i_rst_n;
    assign w_in_acc    = i_valid && !o_stall;

    // truncated mean of the full window
    assign w_avg_adj = r_sum + (r_sum[SW-1] ? SW'(WINDOW - 1) : SW'(0));
    assign w_avg     = w_avg_adj[SW-1:L];

    // distance gate
    assign w_diff  = DW'(w_avg) - DW'(i_sample);
    assign w_mag   = w_diff[DW-1] ? (DW'(0) - w_diff) : w_diff;
    assign w_store = !w_full || (w_mag <= {1'b0, r_tol});
    assign w_store_go = w_in_acc && w_store;

    // next window state: one pointer serves fill and replacement
    assign w_old   = w_full ? $signed(w_rd_data) : '0;
    assign n_sum   = w_store_go ? (r_sum + SW'(i_sample) - SW'(w_old)) : r_sum;
    assign n_count = (w_store_go && !w_full) ? (r_count + CW'(1)) : r_count;
    assign n_ptr   = w_store_go ? (r_ptr + L'(1)) : r_ptr;

    // ring storage, read address is the next write pointer
    ogma_ram #(
        .WIDTH (OGMA_SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_store_go),
        .i_wr_addr (r_ptr),
        .i_wr_data (i_sample),
        .i_rd_addr (n_ptr),
        .o_rd_data (w_rd_data)
    );

    // window state and tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_ptr   <= '0;
            r_tol   <= OGMA_TOL_RESET;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
        end
    end

    // middle stage: state after this word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_b_ready) begin
            r_b_valid <= w_in_acc;
        end
        if (w_b_ready) begin
            r_b_sum   <= n_sum;
            r_b_count <= n_count;
            r_b_acc   <= w_store;
        end
    end

    // output stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_o_valid <= r_b_valid;
        end
        if (w_load_out) begin
            r_o_acc  <= r_b_acc;
            r_o_full <= r_b_count[L];
        end
    end

    // output average
    ogma_mean #(
        .WINDOW (WINDOW)
    ) u_mean (
        .i_clk   (i_clk),
        .i_load  (w_load_out),
        .i_sum   (r_b_sum),
        .i_count (r_b_count),
        .o_mean  (o_mean_out)
    );

    assign o_valid       = r_o_valid;
    assign o_accepted    = r_o_acc;
    assign o_window_full = r_o_full;

    // checks
`include "outlier_gated_moving_average_assert.svh"

    `OGMA_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(WINDOW))
    `OGMA_ASSERT_ALWAYS(a_reject_only_full, !(w_in_acc && !w_store) || w_full)
    `OGMA_ASSERT_NEXT(a_ptr_step, w_store_go, r_ptr == $past(r_ptr) + L'(1))

endmodule

// ----- tb/outlier_gated_moving_average_test.sv -----
// ----------------------------------------------------------------------------
// outlier_gated_moving_average_test
// Self-checking bench for the outlier gated moving average. A behavioral
// copy of the ring, sum, fill count and replace pointer predicts every
// output word when its input word is accepted. The checker compares each
// output word field by field against the oldest prediction. Stimulus covers
// the fill phase with extreme samples, the tolerance boundary once the ring
// is full, random gated traffic under several idle and stall mixes, and a
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module outlier_gated_moving_average_test;
    import ogma_pkg::*;

    localparam int          WIN       = OGMA_WINDOW_DEF;
    localparam int unsigned CYC_LIMIT = 400000;
    localparam int          HOLD_LEN  = 300;

    // one predicted output word
    typedef struct {
        logic signed [OGMA_SAMPLE_W-1:0] mean;
        logic                            accepted;
        logic                            full;
    } t_avg_word;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_valid       = 1'b0;
    logic signed [OGMA_SAMPLE_W-1:0] i_sample      = '0;
    logic                            i_stall       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [OGMA_TOL_W-1:0]           i_cfg_wr_data = '0;
    logic                            o_stall;
    logic                            o_valid;
    logic signed [OGMA_SAMPLE_W-1:0] o_mean_out;
    logic                            o_accepted;
    logic                            o_window_full;

    // behavioral window state
    logic signed [OGMA_SAMPLE_W-1:0] ring_mdl [WIN];
    longint                          sum_mdl  = 0;
    int                              fill_mdl = 0;
    int                              ptr_mdl  = 0;
    logic [OGMA_TOL_W-1:0]           tol_mdl  = OGMA_TOL_RESET;

    t_avg_word   pending_avg_q [$];
    int unsigned err_cnt   = 0;
    int unsigned cyc_cnt   = 0;
    int unsigned src_pct   = 0;
    int unsigned snk_pct   = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    outlier_gated_moving_average #(
        .WINDOW(WIN)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mean_out   (o_mean_out),
        .o_accepted   (o_accepted),
        .o_window_full(o_window_full),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output stall: long hold-off on request, otherwise random
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall   <= ($urandom_range(99) < snk_pct);
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cyc_cnt, what, got, want);
        err_cnt++;
    endtask

    // check each output word against the oldest prediction
    always @(posedge i_clk) begin
        t_avg_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_avg_q.size() == 0) begin
                report_mismatch("word with nothing pending, mean", o_mean_out, 0);
            end else begin
                want = pending_avg_q.pop_front();
                if (o_mean_out !== want.mean)
                    report_mismatch("mean_out", o_mean_out, want.mean);
                if (o_accepted !== want.accepted)
                    report_mismatch("accepted", o_accepted, want.accepted);
                if (o_window_full !== want.full)
                    report_mismatch("window_full", o_window_full, want.full);
            end
        end
    end

    function automatic logic signed [OGMA_SAMPLE_W-1:0] clamp16(input longint v);
        longint c;
        c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return c[OGMA_SAMPLE_W-1:0];
    endfunction

    // average reported after the update
    function automatic longint window_avg();
        longint w = WIN;
        if (fill_mdl == 0)
            return 0;
        if (fill_mdl >= WIN)
            return (sum_mdl + ((sum_mdl > 0) ? w / 2 : -(w / 2))) / w;
        return (sum_mdl * fill_mdl) / (w * w);
    endfunction

    // apply one accepted input word to the window copy and queue the result
    function automatic void predict_window_update(input logic signed [OGMA_SAMPLE_W-1:0] smp);
        longint    sv;
        longint    gap;
        longint    avg;
        t_avg_word wd;
        sv          = smp;
        wd.accepted = 1'b0;
        if (fill_mdl < WIN) begin
            // filling: always stored
            ring_mdl[fill_mdl] = smp;
            sum_mdl           += sv;
            fill_mdl++;
            wd.accepted        = 1'b1;
        end else begin
            // full: gate on distance from the truncated mean
            gap = sum_mdl / WIN - sv;
            if (gap < 0)
                gap = -gap;
            if (gap <= longint'(tol_mdl)) begin
                sum_mdl          += sv - longint'(ring_mdl[ptr_mdl]);
                ring_mdl[ptr_mdl] = smp;
                ptr_mdl           = (ptr_mdl + 1) % WIN;
                wd.accepted       = 1'b1;
            end
        end
        avg     = window_avg();
        wd.mean = avg[OGMA_SAMPLE_W-1:0];
        wd.full = (fill_mdl >= WIN);
        pending_avg_q = {pending_avg_q, wd};
    endfunction

    // trunc mean used by the gate
    function automatic longint gate_mean();
        return sum_mdl / WIN;
    endfunction

    // random sample once full: mostly near the mean, some at the edge, rest noise
    function automatic logic signed [OGMA_SAMPLE_W-1:0] gated_pick();
        longint      off;
        longint      lim;
        int unsigned r;
        logic [31:0] rw;
        r = $urandom_range(99);
        if (r < 60) begin
            lim = (tol_mdl > 4000) ? 4000 : tol_mdl;
            off = $urandom_range(int'(lim));
        end else if (r < 75) begin
            off = longint'(tol_mdl) + $urandom_range(1);
        end else begin
            rw = $urandom;
            return rw[OGMA_SAMPLE_W-1:0];
        end
        if ($urandom_range(1))
            off = -off;
        return clamp16(gate_mean() + off);
    endfunction

    task automatic set_idling(input int unsigned src, input int unsigned snk);
        src_pct = src;
        snk_pct <= snk;
    endtask

    // offer one input word, wait for accept, then predict
    task automatic send_word(input logic signed [OGMA_SAMPLE_W-1:0] smp);
        if (src_pct != 0 && $urandom_range(99) < src_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_pct)
                @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_window_update(smp);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_avg_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write only while the block is idle
    task automatic write_tolerance(input logic [OGMA_TOL_W-1:0] val);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tol_mdl        = val;
    endtask

    // fill phase ignores tolerance, even zero; extremes exercise partial mean
    task automatic test_fill_extremes();
        write_tolerance('0);
        set_idling(0, 0);
        send_word(16'sh7fff);
        send_word(-16'sh8000);
        send_word(16'sh7fff);
        send_word(-16'sh8000);
        send_word(16'sh0000);
        send_word(-16'sh0001);
        send_word(16'sh0001);
        send_word(-16'sh8000);
        send_word(-16'sh8000);
        send_word(16'sh7fff);
    endtask

    // rest of the fill with mixed idling
    task automatic test_fill_random();
        logic [31:0] rw;
        int          n;
        n = 0;
        write_tolerance(OGMA_TOL_RESET);
        while (fill_mdl < WIN) begin
            case ((n / 128) % 4)
                0: set_idling(0, 0);
                1: set_idling(87, 0);
                2: set_idling(0, 87);
                default: set_idling(11, 11);
            endcase
            rw = $urandom;
            if ($urandom_range(1))
                send_word(rw[OGMA_SAMPLE_W-1:0]);
            else
                send_word(clamp16(1000 + longint'($urandom_range(6000)) - 3000));
            n++;
        end
    endtask

    // accept/reject right at the tolerance edge, tolerance zero and maximum
    task automatic test_gate_boundary();
        set_idling(0, 0);
        write_tolerance(16'd150);
        send_word(clamp16(gate_mean() + 150));
        send_word(clamp16(gate_mean() - 150));
        send_word(clamp16(gate_mean() + 151));
        send_word(clamp16(gate_mean() - 151));
        send_word(16'sh7fff);
        send_word(-16'sh8000);
        write_tolerance('0);
        send_word(clamp16(gate_mean()));
        send_word(clamp16(gate_mean() + 1));
        send_word(clamp16(gate_mean() - 1));
        write_tolerance('1);
        send_word(16'sh7fff);
        send_word(-16'sh8000);
        send_word(clamp16(gate_mean()));
    endtask

    // random gated traffic, one tolerance and idle mix per phase
    task automatic test_gate_random();
        logic [31:0] rw;
        for (int ph = 0; ph < 4; ph++) begin
            rw = $urandom;
            case (ph)
                0: begin
                    write_tolerance(rw[OGMA_TOL_W-1:0]);
                    set_idling(0, 0);
                end
                1: begin
                    write_tolerance('0);
                    set_idling(87, 0);
                end
                2: begin
                    write_tolerance('1);
                    set_idling(0, 87);
                end
                default: begin
                    write_tolerance(16'd300);
                    set_idling(11, 11);
                end
            endcase
            repeat (200) send_word(gated_pick());
        end
    endtask

    // long output hold-off while input keeps coming; block must stall input
    task automatic test_backpressure();
        write_tolerance(16'd500);
        set_idling(0, 0);
        hold_req <= hold_req + 1;
        repeat (40) send_word(gated_pick());
        set_idling(11, 11);
        repeat (10) send_word(gated_pick());
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_extremes();
        test_fill_random();
        test_gate_boundary();
        test_gate_random();
        test_backpressure();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pending_avg_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
